### rtl/assert_macros.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Cause seen at one edge implies effect at the next edge.
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

### rtl/fsp_pkg.sv
package fsp_pkg;

    localparam int BYTES_W = 5;
    localparam int NUM_CFG = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int MAX_RES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INT_BYTES         = 3'd0,
        CFG_LONG_BYTES        = 3'd1,
        CFG_LONG_LONG_BYTES   = 3'd2,
        CFG_LONG_DOUBLE_BYTES = 3'd3,
        CFG_INTMAX_BYTES      = 3'd4,
        CFG_SIZE_BYTES        = 3'd5,
        CFG_POINTER_BYTES     = 3'd6,
        CFG_WIDE_CHAR_BYTES   = 3'd7
    } cfg_idx_t;

    localparam logic [BYTES_W-1:0] RST_INT_BYTES         = 5'd4;
    localparam logic [BYTES_W-1:0] RST_LONG_BYTES        = 5'd8;
    localparam logic [BYTES_W-1:0] RST_LONG_LONG_BYTES   = 5'd8;
    localparam logic [BYTES_W-1:0] RST_LONG_DOUBLE_BYTES = 5'd16;
    localparam logic [BYTES_W-1:0] RST_INTMAX_BYTES      = 5'd8;
    localparam logic [BYTES_W-1:0] RST_SIZE_BYTES        = 5'd8;
    localparam logic [BYTES_W-1:0] RST_POINTER_BYTES     = 5'd8;
    localparam logic [BYTES_W-1:0] RST_WIDE_CHAR_BYTES   = 5'd4;

    typedef struct packed {
        logic [BYTES_W-1:0] int_bytes;
        logic [BYTES_W-1:0] long_bytes;
        logic [BYTES_W-1:0] long_long_bytes;
        logic [BYTES_W-1:0] long_double_bytes;
        logic [BYTES_W-1:0] intmax_bytes;
        logic [BYTES_W-1:0] size_bytes;
        logic [BYTES_W-1:0] pointer_bytes;
        logic [BYTES_W-1:0] wide_char_bytes;
    } cfg_t;

    typedef enum logic [2:0] {
        KIND_SIZED = 3'd0,
        KIND_STR   = 3'd1,
        KIND_WSTR  = 3'd2,
        KIND_NONE  = 3'd3,
        KIND_END   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTES_W-1:0] arg_bytes;
    } res_t;

    // Results caused by one character, slot 0 first.
    typedef struct packed {
        res_t [MAX_RES-1:0] slot;
        logic [1:0]         count;
    } bundle_t;

endpackage

### rtl/fsp_cfg_regs.sv
module fsp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsp_pkg::BYTES_W-1:0]        cfg_wdata,
    output fsp_pkg::cfg_t                      cfg
);

    fsp_pkg::cfg_t cfg_reg;
    fsp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (fsp_pkg::cfg_idx_t'(cfg_index))
                fsp_pkg::CFG_INT_BYTES:         cfg_next.int_bytes         = cfg_wdata;
                fsp_pkg::CFG_LONG_BYTES:        cfg_next.long_bytes        = cfg_wdata;
                fsp_pkg::CFG_LONG_LONG_BYTES:   cfg_next.long_long_bytes   = cfg_wdata;
                fsp_pkg::CFG_LONG_DOUBLE_BYTES: cfg_next.long_double_bytes = cfg_wdata;
                fsp_pkg::CFG_INTMAX_BYTES:      cfg_next.intmax_bytes      = cfg_wdata;
                fsp_pkg::CFG_SIZE_BYTES:        cfg_next.size_bytes        = cfg_wdata;
                fsp_pkg::CFG_POINTER_BYTES:     cfg_next.pointer_bytes     = cfg_wdata;
                fsp_pkg::CFG_WIDE_CHAR_BYTES:   cfg_next.wide_char_bytes   = cfg_wdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.int_bytes         <= fsp_pkg::RST_INT_BYTES;
            cfg_reg.long_bytes        <= fsp_pkg::RST_LONG_BYTES;
            cfg_reg.long_long_bytes   <= fsp_pkg::RST_LONG_LONG_BYTES;
            cfg_reg.long_double_bytes <= fsp_pkg::RST_LONG_DOUBLE_BYTES;
            cfg_reg.intmax_bytes      <= fsp_pkg::RST_INTMAX_BYTES;
            cfg_reg.size_bytes        <= fsp_pkg::RST_SIZE_BYTES;
            cfg_reg.pointer_bytes     <= fsp_pkg::RST_POINTER_BYTES;
            cfg_reg.wide_char_bytes   <= fsp_pkg::RST_WIDE_CHAR_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/fsp_parser.sv
`include "assert_macros.svh"

module fsp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       ch,
    input  logic             is_final,
    input  fsp_pkg::cfg_t    cfg,
    output fsp_pkg::bundle_t bundle
);

    typedef enum logic [3:0] {
        PH_TEXT     = 4'd0,
        PH_PERCENT  = 4'd1,
        PH_FLAG     = 4'd2,
        PH_STAR     = 4'd3,
        PH_DIGITS   = 4'd4,
        PH_LEN      = 4'd5,
        PH_AFTER_H  = 4'd6,
        PH_AFTER_L  = 4'd7,
        PH_CONV     = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        MOD_NONE = 3'd0,
        MOD_HH   = 3'd1,
        MOD_H    = 3'd2,
        MOD_L    = 3'd3,
        MOD_LL   = 3'd4,
        MOD_LD   = 3'd5,
        MOD_J    = 3'd6,
        MOD_Z    = 3'd7
    } mod_t;

    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_STAR    = 8'h2a;
    localparam logic [7:0] CHR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHR_LC_H    = 8'h68;
    localparam logic [7:0] CHR_LC_L    = 8'h6c;
    localparam logic [7:0] CHR_UC_L    = 8'h4c;

    localparam logic [fsp_pkg::BYTES_W-1:0] BYTES_ONE    = 5'd1;
    localparam logic [fsp_pkg::BYTES_W-1:0] BYTES_TWO    = 5'd2;
    localparam logic [fsp_pkg::BYTES_W-1:0] BYTES_DOUBLE = 5'd8;

    phase_t phase_reg;
    phase_t phase_next;
    logic   odd_reg;
    logic   odd_next;
    logic   star_reg;
    logic   star_next;
    mod_t   mod_reg;
    mod_t   mod_next;

    logic                          spec_go;
    phase_t                        p;
    logic                          done;
    mod_t                          m;
    fsp_pkg::kind_t                cv_kind;
    logic [fsp_pkg::BYTES_W-1:0]   cv_bytes;
    logic                          is_flag;
    logic                          is_digit;
    logic                          unfinished;
    fsp_pkg::res_t [fsp_pkg::MAX_RES-1:0] slot;
    logic [1:0]                    cnt;

    // # 0 - space + ' I
    assign is_flag = (ch == 8'h23) || (ch == 8'h30) || (ch == 8'h2d) || (ch == 8'h20) ||
                     (ch == 8'h2b) || (ch == 8'h27) || (ch == 8'h49);
    assign is_digit = ((ch >= 8'h30) && (ch <= 8'h39)) || (ch == 8'h2e);

    // Conversion character under modifier m.
    always_comb
    begin
        cv_kind  = fsp_pkg::KIND_SIZED;
        cv_bytes = '0;
        unique case (ch)
            8'h64, 8'h69, 8'h6f, 8'h75, 8'h78, 8'h58:   // d i o u x X
            begin
                unique case (m)
                    MOD_HH:  cv_bytes = BYTES_ONE;
                    MOD_H:   cv_bytes = BYTES_TWO;
                    MOD_L:   cv_bytes = cfg.long_bytes;
                    MOD_LL:  cv_bytes = cfg.long_long_bytes;
                    MOD_J:   cv_bytes = cfg.intmax_bytes;
                    MOD_Z:   cv_bytes = cfg.size_bytes;
                    default: cv_bytes = cfg.int_bytes;
                endcase
            end
            8'h65, 8'h45, 8'h66, 8'h46, 8'h67, 8'h47, 8'h61, 8'h41:   // e E f F g G a A
                cv_bytes = (m == MOD_LD) ? cfg.long_double_bytes : BYTES_DOUBLE;
            8'h63:   // c
                cv_bytes = (m == MOD_L) ? cfg.wide_char_bytes : BYTES_ONE;
            8'h43:   // C
                cv_bytes = cfg.wide_char_bytes;
            8'h73:   // s
                cv_kind = (m == MOD_L) ? fsp_pkg::KIND_WSTR : fsp_pkg::KIND_STR;
            8'h53:   // S
                cv_kind = fsp_pkg::KIND_WSTR;
            8'h70, 8'h6e:   // p n
                cv_bytes = cfg.pointer_bytes;
            default:
                cv_kind = fsp_pkg::KIND_NONE;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        odd_next   = odd_reg;
        star_next  = star_reg;
        mod_next   = mod_reg;
        spec_go    = 1'b0;
        p          = phase_reg;
        done       = 1'b0;
        m          = mod_reg;
        slot       = '0;
        cnt        = 2'd0;

        unique case (phase_reg)
            PH_TEXT:
            begin
                if (ch == CHR_PERCENT)
                begin
                    phase_next = PH_PERCENT;
                    odd_next   = 1'b1;
                end
            end
            PH_PERCENT:
            begin
                if (ch == CHR_PERCENT)
                begin
                    odd_next = ~odd_reg;
                end
                else if (odd_reg)
                begin
                    spec_go = 1'b1;
                    p       = PH_FLAG;
                end
                else
                begin
                    odd_next   = 1'b0;
                    star_next  = 1'b0;
                    mod_next   = MOD_NONE;
                    phase_next = PH_TEXT;
                end
            end
            default:
                spec_go = 1'b1;
        endcase

        // Specifier fields fall through to the next one when absent.
        if (spec_go)
        begin
            if (p == PH_FLAG)
            begin
                if (is_flag)
                begin
                    phase_next = PH_STAR;
                    done       = 1'b1;
                end
                else
                begin
                    p = PH_STAR;
                end
            end
            if (!done && p == PH_STAR)
            begin
                if (ch == CHR_STAR)
                begin
                    star_next  = 1'b1;
                    phase_next = PH_DIGITS;
                    done       = 1'b1;
                end
                else
                begin
                    p = PH_DIGITS;
                end
            end
            if (!done && p == PH_DIGITS)
            begin
                if (is_digit)
                begin
                    phase_next = PH_DIGITS;
                    done       = 1'b1;
                end
                else if (star_reg && ch == CHR_DOLLAR)
                begin
                    phase_next = PH_LEN;
                    done       = 1'b1;
                end
                else
                begin
                    p = PH_LEN;
                end
            end
            if (!done && p == PH_LEN)
            begin
                done = 1'b1;
                priority case (ch)
                    CHR_LC_H: phase_next = PH_AFTER_H;
                    CHR_LC_L: phase_next = PH_AFTER_L;
                    8'h71:    // q
                    begin
                        mod_next   = MOD_LL;
                        phase_next = PH_CONV;
                    end
                    CHR_UC_L:
                    begin
                        mod_next   = MOD_LD;
                        phase_next = PH_CONV;
                    end
                    8'h6a:    // j
                    begin
                        mod_next   = MOD_J;
                        phase_next = PH_CONV;
                    end
                    8'h7a, 8'h5a, 8'h74:   // z Z t
                    begin
                        mod_next   = MOD_Z;
                        phase_next = PH_CONV;
                    end
                    default:
                    begin
                        done = 1'b0;
                        p    = PH_CONV;
                    end
                endcase
            end
            if (!done && p == PH_AFTER_H)
            begin
                if (ch == CHR_LC_H)
                begin
                    mod_next   = MOD_HH;
                    phase_next = PH_CONV;
                    done       = 1'b1;
                end
                else
                begin
                    m = MOD_H;
                end
            end
            else if (!done && p == PH_AFTER_L)
            begin
                if (ch == CHR_LC_L)
                begin
                    mod_next   = MOD_LL;
                    phase_next = PH_CONV;
                    done       = 1'b1;
                end
                else
                begin
                    m = MOD_L;
                end
            end
            if (!done)
            begin
                slot[0].kind      = cv_kind;
                slot[0].arg_bytes = (cv_kind == fsp_pkg::KIND_SIZED) ? cv_bytes : '0;
                cnt               = 2'd1;
                star_next         = 1'b0;
                mod_next          = MOD_NONE;
                if (ch == CHR_PERCENT)
                begin
                    phase_next = PH_PERCENT;
                    odd_next   = 1'b1;
                end
                else
                begin
                    phase_next = PH_TEXT;
                    odd_next   = 1'b0;
                end
            end
        end

        unfinished = (phase_next == PH_PERCENT && odd_next) ||
                     (phase_next != PH_TEXT && phase_next != PH_PERCENT);

        if (is_final)
        begin
            if (unfinished)
            begin
                slot[cnt].kind      = fsp_pkg::KIND_NONE;
                slot[cnt].arg_bytes = '0;
                cnt                 = cnt + 2'd1;
            end
            slot[cnt].kind      = fsp_pkg::KIND_END;
            slot[cnt].arg_bytes = '0;
            cnt                 = cnt + 2'd1;
            phase_next          = PH_TEXT;
            odd_next            = 1'b0;
            star_next           = 1'b0;
            mod_next            = MOD_NONE;
        end

        bundle.slot  = slot;
        bundle.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            odd_reg   <= 1'b0;
            star_reg  <= 1'b0;
            mod_reg   <= MOD_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            odd_reg   <= odd_next;
            star_reg  <= star_next;
            mod_reg   <= mod_next;
        end
    end

    `ASSERT_ALWAYS(a_final_has_end, !(fire && is_final && bundle.count == 2'd0), "final char without end result")
    `ASSERT_NEXT(a_final_resets, fire && is_final, phase_reg == PH_TEXT && !odd_reg && !star_reg && mod_reg == MOD_NONE, "state not cleared after end")

endmodule

### rtl/fsp_out_buf.sv
`include "assert_macros.svh"

module fsp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fsp_pkg::bundle_t bundle,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output fsp_pkg::res_t    head
);

    fsp_pkg::res_t [fsp_pkg::MAX_RES-1:0] slot_reg;
    fsp_pkg::res_t [fsp_pkg::MAX_RES-1:0] slot_next;
    logic [1:0]                           cnt_reg;
    logic [1:0]                           cnt_next;
    logic                                 pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign head      = slot_reg[0];

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            slot_next = {fsp_pkg::res_t'('0), slot_reg[2], slot_reg[1]};
            cnt_next  = cnt_reg - 2'd1;
        end
        if (load)
        begin
            slot_next = bundle.slot;
            cnt_next  = bundle.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    `ASSERT_ALWAYS(a_load_when_free, !load || cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop), "load over pending results")
    `ASSERT_ALWAYS(a_cnt_range, cnt_reg != 2'd3 || (slot_reg[2].kind == fsp_pkg::KIND_END), "three results without end")

endmodule

### rtl/format_spec_arg_size_parser.sv
// A character waits in the input register until the output buffer can take its results, which it then offers.
// Throughput: one character per cycle while each yields at most one result and out_ready is high;
// a character yielding several results (up to three, at string end) holds back the next until they drain.
// Reset (rst_n, async low): parser state back to text skipping, buffers empty,
// size registers to their defaults.
`include "assert_macros.svh"

module format_spec_arg_size_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsp_pkg::BYTES_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    ch,
    input  logic                          is_final,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    kind,
    output logic [fsp_pkg::BYTES_W-1:0]   arg_bytes,
    output logic                          end_of_format
);

    fsp_pkg::cfg_t    cfg;
    fsp_pkg::bundle_t bundle;
    fsp_pkg::res_t    head;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] ch_reg;
    logic       fin_reg;
    logic       can_load;
    logic       fire;

    assign fire          = in_valid_reg && can_load;
    assign in_ready      = !in_valid_reg || fire;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            fin_reg <= is_final;
        end
    end

    fsp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fsp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .ch       (ch_reg),
        .is_final (fin_reg),
        .cfg      (cfg),
        .bundle   (bundle)
    );

    fsp_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .bundle    (bundle),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind          = head.kind;
    assign arg_bytes     = head.arg_bytes;
    assign end_of_format = (head.kind == fsp_pkg::KIND_END);

    `ASSERT_NEXT(a_held_item, in_valid_reg && !fire,
                 in_valid_reg && $stable(ch_reg) && $stable(fin_reg), "held character lost")

endmodule
